// ----- rtl/excitable_media_automaton_top_assert.svh -----
// assertion macros for the automaton block
`ifndef EXCITABLE_MEDIA_AUTOMATON_TOP_ASSERT_SVH
`define EXCITABLE_MEDIA_AUTOMATON_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define EMA_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define EMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EMA_ASSERT(label, ante, cons)
`define EMA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/ema_pkg.sv -----
`timescale 1ns / 1ps
package ema_pkg;
    localparam int EMA_MAX_WIDTH  = 64;
    localparam int EMA_MAX_HEIGHT = 64;
    localparam int EMA_CELL_BITS  = 4;

    localparam logic [6:0] GRID_WIDTH_RST  = 7'd64;
    localparam logic [6:0] GRID_HEIGHT_RST = 7'd64;
    localparam logic [3:0] STATE_COUNT_RST = 4'd12;
    localparam logic [3:0] THRESHOLD_RST   = 4'd2;
    localparam logic [3:0] EXCITED_MAX_RST = 4'd2;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_STATE_COUNT = 3'd2;
    localparam logic [2:0] CFG_THRESHOLD   = 3'd3;
    localparam logic [2:0] CFG_EXCITED_MAX = 3'd4;
endpackage

// ----- rtl/excitable_media_automaton_top.sv -----
`timescale 1ns / 1ps
// Greenberg-Hastings automaton on a wrapped grid held in two banks of block RAM.
// After reset a clearing pass zeroes every address of both banks, during which no
// item is taken. A cell write is done as it is taken; a cell read goes through the
// registered RAM read and the result hand-off before it reaches the output.
// An advance sweeps the whole store through the single read port: each cell inside
// the active area reads its centre and eight neighbours, drains, then writes; every
// other cell reads only its centre, drains and writes it back unchanged. A finished
// result waits in an output register, and the next item is taken only once that
// register is free or being read out.
`include "excitable_media_automaton_top_assert.svh"
module excitable_media_automaton_top
    import ema_pkg::*;
#(
    parameter int MAX_WIDTH  = EMA_MAX_WIDTH,
    parameter int MAX_HEIGHT = EMA_MAX_HEIGHT,
    parameter int CELL_BITS  = EMA_CELL_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [5:0] column,
    input  logic [5:0] row,
    input  logic [3:0] write_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] read_value,
    output logic       generation_done
);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DWX   = $clog2(MAX_WIDTH + 1);
    localparam int DWY   = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_FINISH,
        ST_ADV_RD,
        ST_ADV_LAST,
        ST_ADV_WR
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      clr_reg;
    logic               bank_reg;
    logic [XW-1:0]      x_reg;
    logic [YW-1:0]      y_reg;
    logic [3:0]         k_reg;
    logic [3:0]         tag_reg;
    logic               tag_vld_reg;
    logic [CELL_BITS-1:0] center_reg;
    logic [3:0]         exc_reg;
    logic [3:0]         pend_value_reg;
    logic               pend_gen_reg;
    logic               out_valid_reg;
    logic [3:0]         read_value_reg;
    logic               generation_done_reg;
    logic [6:0]         grid_width_reg;
    logic [6:0]         grid_height_reg;
    logic [3:0]         state_count_reg;
    logic [3:0]         threshold_reg;
    logic [3:0]         excited_max_reg;

    logic [DWX-1:0]     w_eff;
    logic [DWY-1:0]     h_eff;
    logic               active;
    logic [XW-1:0]      xm;
    logic [XW-1:0]      xp;
    logic [YW-1:0]      ym;
    logic [YW-1:0]      yp;
    logic [XW-1:0]      sel_x;
    logic [YW-1:0]      sel_y;
    logic [AW-1:0]      nb_addr;
    logic [AW-1:0]      center_addr;
    logic [AW-1:0]      op_addr;
    logic               op_inside;
    logic               last_cell;
    logic               in_accept;
    logic               out_free;
    logic               out_load;
    logic               we_a;
    logic               we_b;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [CELL_BITS-1:0] ram_wdata;
    logic [CELL_BITS-1:0] rdata_a;
    logic [CELL_BITS-1:0] rdata_b;
    logic [CELL_BITS-1:0] rdata;
    logic [3:0]         rdata4;
    logic               rdata_exc;
    logic [CELL_BITS-1:0] new_value;
    logic [3:0]         exc_next;

    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            w_eff = DWX'(1);
        end
        else if (32'(grid_width_reg) > MAX_WIDTH)
        begin
            w_eff = DWX'(MAX_WIDTH);
        end
        else
        begin
            w_eff = DWX'(grid_width_reg);
        end
        if (grid_height_reg == '0)
        begin
            h_eff = DWY'(1);
        end
        else if (32'(grid_height_reg) > MAX_HEIGHT)
        begin
            h_eff = DWY'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = DWY'(grid_height_reg);
        end
    end

    assign active = (32'(x_reg) < 32'(w_eff)) && (32'(y_reg) < 32'(h_eff));
    assign xm = (x_reg == '0) ? XW'(w_eff - DWX'(1)) : x_reg - XW'(1);
    assign xp = (32'(x_reg) + 32'd1 == 32'(w_eff)) ? '0 : x_reg + XW'(1);
    assign ym = (y_reg == '0) ? YW'(h_eff - DWY'(1)) : y_reg - YW'(1);
    assign yp = (32'(y_reg) + 32'd1 == 32'(h_eff)) ? '0 : y_reg + YW'(1);

    // neighbour order: centre, then row above, own row, row below
    always_comb
    begin
        case (k_reg)
            4'd1:    begin sel_y = ym;    sel_x = xm;    end
            4'd2:    begin sel_y = ym;    sel_x = x_reg; end
            4'd3:    begin sel_y = ym;    sel_x = xp;    end
            4'd4:    begin sel_y = y_reg; sel_x = xm;    end
            4'd5:    begin sel_y = y_reg; sel_x = xp;    end
            4'd6:    begin sel_y = yp;    sel_x = xm;    end
            4'd7:    begin sel_y = yp;    sel_x = x_reg; end
            4'd8:    begin sel_y = yp;    sel_x = xp;    end
            default: begin sel_y = y_reg; sel_x = x_reg; end
        endcase
    end

    assign nb_addr     = AW'(32'(sel_y) * MAX_WIDTH + 32'(sel_x));
    assign center_addr = AW'(32'(y_reg) * MAX_WIDTH + 32'(x_reg));
    assign op_addr     = AW'(32'(row) * MAX_WIDTH + 32'(column));
    assign op_inside   = (32'(column) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT);
    assign last_cell   = (x_reg == XW'(MAX_WIDTH - 1)) && (y_reg == YW'(MAX_HEIGHT - 1));

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = in_valid && in_ready;
    assign out_load  = ((state_reg == ST_IDLE) && in_accept && operation != OP_ADVANCE
                        && !(operation == OP_READ && op_inside))
                       || ((state_reg == ST_FINISH) && out_free);

    assign rdata     = bank_reg ? rdata_b : rdata_a;
    assign rdata4    = 4'(32'(rdata));
    assign rdata_exc = (rdata != '0) && (32'(rdata) <= 32'(excited_max_reg));
    assign exc_next  = (tag_vld_reg && tag_reg != 4'd0 && rdata_exc) ? exc_reg + 4'd1 : exc_reg;

    always_comb
    begin
        if (!active)
        begin
            new_value = center_reg;
        end
        else if (center_reg == '0)
        begin
            new_value = (32'(exc_reg) >= 32'(threshold_reg)) ? CELL_BITS'(1) : '0;
        end
        else if (32'(center_reg) + 32'd1 < 32'(state_count_reg))
        begin
            new_value = CELL_BITS'(32'(center_reg) + 32'd1);
        end
        else
        begin
            new_value = '0;
        end
    end

    always_comb
    begin
        we_a      = 1'b0;
        we_b      = 1'b0;
        ram_waddr = op_addr;
        ram_raddr = op_addr;
        ram_wdata = CELL_BITS'(write_value);
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_waddr = clr_reg;
                ram_wdata = '0;
                we_a      = 1'b1;
                we_b      = 1'b1;
            end
            ST_IDLE:
            begin
                if (in_accept && operation == OP_WRITE && op_inside)
                begin
                    we_a = !bank_reg;
                    we_b = bank_reg;
                end
            end
            ST_ADV_RD:
            begin
                ram_raddr = nb_addr;
            end
            ST_ADV_WR:
            begin
                ram_waddr = center_addr;
                ram_wdata = new_value;
                we_a      = bank_reg;
                we_b      = !bank_reg;
            end
            default:
            begin
            end
        endcase
    end

    ema_ram #(
        .WIDTH(CELL_BITS),
        .DEPTH(CELLS)
    ) u_bank_a (
        .clk  (clk),
        .we   (we_a),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(rdata_a)
    );

    ema_ram #(
        .WIDTH(CELL_BITS),
        .DEPTH(CELLS)
    ) u_bank_b (
        .clk  (clk),
        .we   (we_b),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            state_count_reg <= STATE_COUNT_RST;
            threshold_reg   <= THRESHOLD_RST;
            excited_max_reg <= EXCITED_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                CFG_STATE_COUNT: state_count_reg <= cfg_data[3:0];
                CFG_THRESHOLD:   threshold_reg   <= cfg_data[3:0];
                CFG_EXCITED_MAX: excited_max_reg <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_CLEAR;
            clr_reg             <= '0;
            bank_reg            <= 1'b0;
            x_reg               <= '0;
            y_reg               <= '0;
            k_reg               <= '0;
            tag_reg             <= '0;
            tag_vld_reg         <= 1'b0;
            center_reg          <= '0;
            exc_reg             <= '0;
            pend_value_reg      <= '0;
            pend_gen_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            read_value_reg      <= '0;
            generation_done_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(CELLS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (operation == OP_READ && op_inside)
                        begin
                            state_reg <= ST_RD_WAIT;
                        end
                        else if (operation == OP_ADVANCE)
                        begin
                            x_reg       <= '0;
                            y_reg       <= '0;
                            k_reg       <= '0;
                            tag_vld_reg <= 1'b0;
                            state_reg   <= ST_ADV_RD;
                        end
                        else
                        begin
                            read_value_reg      <= '0;
                            generation_done_reg <= 1'b0;
                        end
                    end
                end
                ST_RD_WAIT:
                begin
                    pend_value_reg <= rdata4;
                    pend_gen_reg   <= 1'b0;
                    state_reg      <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        read_value_reg      <= pend_value_reg;
                        generation_done_reg <= pend_gen_reg;
                        state_reg           <= ST_IDLE;
                    end
                end
                ST_ADV_RD:
                begin
                    if (tag_vld_reg && tag_reg == 4'd0)
                    begin
                        center_reg <= rdata;
                    end
                    exc_reg     <= (k_reg == 4'd0) ? 4'd0 : exc_next;
                    tag_reg     <= k_reg;
                    tag_vld_reg <= 1'b1;
                    if ((k_reg == 4'd0 && !active) || k_reg == 4'd8)
                    begin
                        state_reg <= ST_ADV_LAST;
                    end
                    else
                    begin
                        k_reg <= k_reg + 4'd1;
                    end
                end
                ST_ADV_LAST:
                begin
                    if (tag_reg == 4'd0)
                    begin
                        center_reg <= rdata;
                    end
                    exc_reg     <= exc_next;
                    tag_vld_reg <= 1'b0;
                    state_reg   <= ST_ADV_WR;
                end
                ST_ADV_WR:
                begin
                    k_reg <= '0;
                    if (last_cell)
                    begin
                        bank_reg       <= !bank_reg;
                        pend_value_reg <= '0;
                        pend_gen_reg   <= 1'b1;
                        state_reg      <= ST_FINISH;
                    end
                    else
                    begin
                        if (x_reg == XW'(MAX_WIDTH - 1))
                        begin
                            x_reg <= '0;
                            y_reg <= y_reg + YW'(1);
                        end
                        else
                        begin
                            x_reg <= x_reg + XW'(1);
                        end
                        state_reg <= ST_ADV_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_value      = read_value_reg;
    assign generation_done = generation_done_reg;

    `EMA_ASSERT(a_dual_write_clear, we_a && we_b, state_reg == ST_CLEAR)
    `EMA_ASSERT(a_gen_zero_value, out_valid_reg && generation_done_reg, read_value_reg == 4'd0)
    `EMA_ASSERT_NEXT(a_adv_busy, in_accept && operation == OP_ADVANCE, state_reg == ST_ADV_RD)
    `EMA_ASSERT(a_bank_flip, !$stable(bank_reg), $past(state_reg) == ST_ADV_WR)
endmodule

// ----- rtl/ema_ram.sv -----
`timescale 1ns / 1ps
module ema_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
